// ===== src/bgc_pkg.sv =====
// shared types and constants of the button gesture classifier
`default_nettype none

package bgc_pkg;

  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 3;
  localparam int TIME_IN_W   = 32;
  localparam int ID_W        = 64;
  localparam int DEV_ID_W    = 16;
  localparam int WINDOW_W    = 16;
  localparam int GESTURE_W   = 2;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_HIGH     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LOCAL_MODE      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LOCAL_DEVICE_ID = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SINGLE_EVENT_ID = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_DOUBLE_EVENT_ID = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG_EVENT_ID   = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_MS       = 3'd6;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd500;

  // item commands
  localparam logic CMD_PIN  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // gesture codes
  localparam logic [GESTURE_W-1:0] GEST_SINGLE = 2'd0;
  localparam logic [GESTURE_W-1:0] GEST_DOUBLE = 2'd1;
  localparam logic [GESTURE_W-1:0] GEST_LONG   = 2'd2;

  typedef struct packed {
    logic                active_high;
    logic                local_mode;
    logic [DEV_ID_W-1:0] local_device_id;
    logic [ID_W-1:0]     single_event_id;
    logic [ID_W-1:0]     double_event_id;
    logic [ID_W-1:0]     long_event_id;
    logic [WINDOW_W-1:0] window_ms;
  } cfg_t;

  typedef struct packed {
    logic                 cmd;
    logic                 pin_level;
    logic [TIME_IN_W-1:0] time_ms;
  } item_t;

  typedef struct packed {
    logic                 fire;
    logic [GESTURE_W-1:0] gesture;
    logic                 to_local;
    logic [ID_W-1:0]      target_id;
  } result_t;

endpackage

`default_nettype wire

// ===== src/bgc_item_if.sv =====
// input word channel: pin change or tick
`default_nettype none

interface bgc_item_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic                         pin_level;
  logic [bgc_pkg::TIME_IN_W-1:0] time_ms;

  modport source (output valid, output cmd, output pin_level, output time_ms, input ready);
  modport sink   (input valid, input cmd, input pin_level, input time_ms, output ready);
endinterface

`default_nettype wire

// ===== src/bgc_result_if.sv =====
// result word channel: classified gesture and its target id
`default_nettype none

interface bgc_result_if;
  logic                          valid;
  logic                          ready;
  logic [bgc_pkg::GESTURE_W-1:0] gesture;
  logic                          to_local;
  logic [bgc_pkg::ID_W-1:0]      target_id;

  modport source (output valid, output gesture, output to_local, output target_id, input ready);
  modport sink   (input valid, input gesture, input to_local, input target_id, output ready);
endinterface

`default_nettype wire

// ===== src/bgc_cfg_regs.sv =====
// configuration register file of the gesture classifier
`default_nettype none

module bgc_cfg_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [bgc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [bgc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output bgc_pkg::cfg_t                         cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_high     <= 1'b0;
      cfg.local_mode      <= 1'b0;
      cfg.local_device_id <= '0;
      cfg.single_event_id <= '0;
      cfg.double_event_id <= '0;
      cfg.long_event_id   <= '0;
      cfg.window_ms       <= bgc_pkg::WINDOW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bgc_pkg::REG_ACTIVE_HIGH:     cfg.active_high     <= cfg_data[0];
        bgc_pkg::REG_LOCAL_MODE:      cfg.local_mode      <= cfg_data[0];
        bgc_pkg::REG_LOCAL_DEVICE_ID: cfg.local_device_id <= cfg_data[bgc_pkg::DEV_ID_W-1:0];
        bgc_pkg::REG_SINGLE_EVENT_ID: cfg.single_event_id <= cfg_data;
        bgc_pkg::REG_DOUBLE_EVENT_ID: cfg.double_event_id <= cfg_data;
        bgc_pkg::REG_LONG_EVENT_ID:   cfg.long_event_id   <= cfg_data;
        bgc_pkg::REG_WINDOW_MS:       cfg.window_ms       <= cfg_data[bgc_pkg::WINDOW_W-1:0];
        default: ; // unused index, write dropped
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/bgc_core.sv =====
// window state and gesture classification for one word per cycle while en is high
`default_nettype none

module bgc_core #(
  parameter int TIME_BITS = 32
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire bgc_pkg::item_t  item,
  input  wire bgc_pkg::cfg_t   cfg,
  output bgc_pkg::result_t     result
);

  logic                 window_open;
  logic [TIME_BITS-1:0] press_time;
  logic [TIME_BITS-1:0] release_time;
  logic                 second_press;
  logic                 released;

  logic                 window_open_next;
  logic [TIME_BITS-1:0] press_time_next;
  logic [TIME_BITS-1:0] release_time_next;
  logic                 second_press_next;
  logic                 released_next;

  logic [63:0]          time_ext;
  logic [TIME_BITS-1:0] now;
  logic                 pressed;
  logic [TIME_BITS-1:0] elapsed;
  logic [TIME_BITS-1:0] held;
  logic [TIME_BITS-1:0] window_ext;
  logic [17:0]          window_x3;
  logic [TIME_BITS-1:0] long_thr;
  logic                 fire;

  always_comb begin
    time_ext = {{(64-bgc_pkg::TIME_IN_W){1'b0}}, item.time_ms};
    now      = time_ext[TIME_BITS-1:0];
    pressed  = cfg.active_high ? item.pin_level : ~item.pin_level;

    // apply the word to the window state
    window_open_next  = window_open;
    press_time_next   = press_time;
    release_time_next = release_time;
    second_press_next = second_press;
    released_next     = released;
    if (item.cmd == bgc_pkg::CMD_PIN) begin
      if (!window_open && pressed) begin
        window_open_next = 1'b1;
        press_time_next  = now;
      end else if (window_open && !pressed) begin
        release_time_next = now;
        released_next     = 1'b1;
      end else if (window_open && pressed) begin
        second_press_next = 1'b1;
      end
    end

    // window check against the time of this word
    window_ext = {{(TIME_BITS-bgc_pkg::WINDOW_W){1'b0}}, cfg.window_ms};
    elapsed    = now - press_time_next;
    held       = release_time_next - press_time_next;
    window_x3  = {2'b00, cfg.window_ms} + {1'b0, cfg.window_ms, 1'b0};
    long_thr   = {{(TIME_BITS-bgc_pkg::WINDOW_W){1'b0}}, window_x3[17:2]};
    fire       = window_open_next && (second_press_next || (elapsed >= window_ext));

    result.fire      = fire;
    result.to_local  = 1'b0;
    if (second_press_next) begin
      result.gesture   = bgc_pkg::GEST_DOUBLE;
      result.target_id = cfg.double_event_id;
    end else if (!released_next || (held > long_thr)) begin
      result.gesture   = bgc_pkg::GEST_LONG;
      result.target_id = cfg.long_event_id;
    end else if (cfg.local_mode) begin
      result.gesture   = bgc_pkg::GEST_SINGLE;
      result.to_local  = 1'b1;
      result.target_id = {{(bgc_pkg::ID_W-bgc_pkg::DEV_ID_W){1'b0}}, cfg.local_device_id};
    end else begin
      result.gesture   = bgc_pkg::GEST_SINGLE;
      result.target_id = cfg.single_event_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_open  <= 1'b0;
      press_time   <= '0;
      release_time <= '0;
      second_press <= 1'b0;
      released     <= 1'b0;
    end else if (en) begin
      if (fire) begin
        window_open  <= 1'b0;
        press_time   <= '0;
        release_time <= '0;
        second_press <= 1'b0;
        released     <= 1'b0;
      end else begin
        window_open  <= window_open_next;
        press_time   <= press_time_next;
        release_time <= release_time_next;
        second_press <= second_press_next;
        released     <= released_next;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/button_gesture_classifier.sv =====
// top level of the button gesture classifier
//
// usage:
// - item channel takes one word per cycle while ready is high: a pin change (cmd pin, level and
//   timestamp) or a tick (cmd tick, current time in ms)
// - result channel gives one word each time a gesture window closes:
//   gesture code, to_local flag and the selected 64-bit target id
// - config port: cfg_we, cfg_index, cfg_data; write only while idle
// - a taken word waits in the input register and is classified from there; if
//   it closes a window, its result is loaded into the result register
// - throughput: one word per cycle unless the result register stalls; window
//   state update is combinational between the input and result registers
// - reset clears the window state and the valid flags of both word
//   registers and loads the register defaults (window of 500 ms, all ids zero)
// - when the result receiver stalls, the pending result holds; an empty
//   input register still takes one more word, then ready drops
`default_nettype none

module button_gesture_classifier #(
  parameter int TIME_BITS = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  bgc_item_if.sink                             item,
  bgc_result_if.source                         result,
  input  wire logic                            cfg_we,
  input  wire logic [bgc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [bgc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  bgc_pkg::cfg_t    cfg;
  bgc_pkg::item_t   in_word;
  bgc_pkg::result_t core_result;

  logic in_valid;
  logic advance;

  // input register advances whenever the result register can take a word
  assign advance    = in_valid && (!result.valid || result.ready);
  assign item.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      in_word.cmd       <= item.cmd;
      in_word.pin_level <= item.pin_level;
      in_word.time_ms   <= item.time_ms;
    end
  end

  bgc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // state update and classification of the registered word
  bgc_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .item   (in_word),
    .cfg    (cfg),
    .result (core_result)
  );

  // result register: set on a closing window, cleared once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance && core_result.fire) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && core_result.fire) begin
      result.gesture   <= core_result.gesture;
      result.to_local  <= core_result.to_local;
      result.target_id <= core_result.target_id;
    end
  end

endmodule

`default_nettype wire

// ===== dv/bgc_gesture_checker.sv =====
// gesture checker: predicts result words from accepted input words and compares them
`timescale 1ns / 100ps

module bgc_gesture_checker (
  input  logic                            clk,
  input  logic                            rst,
  bgc_item_if                             item,
  bgc_result_if                           result,
  input  logic                            cfg_we,
  input  logic [bgc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bgc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              fail_count,
  output int                              outstanding
);

  typedef struct packed {
    logic [bgc_pkg::GESTURE_W-1:0] code;
    logic                          to_local;
    logic [bgc_pkg::ID_W-1:0]      target;
  } gesture_word_t;

  bgc_pkg::cfg_t                 regs;
  logic                          window_open;
  logic [bgc_pkg::TIME_IN_W-1:0] press_ms;
  logic [bgc_pkg::TIME_IN_W-1:0] release_ms;
  logic                          second_press;
  logic                          released;

  gesture_word_t  gestures_due[$];
  gesture_word_t  due;
  gesture_word_t  predicted;
  bgc_pkg::item_t word;
  int             mismatches = 0;

  function automatic void close_window();
    window_open  = 1'b0;
    press_ms     = '0;
    release_ms   = '0;
    second_press = 1'b0;
    released     = 1'b0;
  endfunction

  function automatic void write_reg(input logic [bgc_pkg::CFG_INDEX_W-1:0] idx,
                                    input logic [bgc_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      bgc_pkg::REG_ACTIVE_HIGH:     regs.active_high     = data[0];
      bgc_pkg::REG_LOCAL_MODE:      regs.local_mode      = data[0];
      bgc_pkg::REG_LOCAL_DEVICE_ID: regs.local_device_id = data[bgc_pkg::DEV_ID_W-1:0];
      bgc_pkg::REG_SINGLE_EVENT_ID: regs.single_event_id = data[bgc_pkg::ID_W-1:0];
      bgc_pkg::REG_DOUBLE_EVENT_ID: regs.double_event_id = data[bgc_pkg::ID_W-1:0];
      bgc_pkg::REG_LONG_EVENT_ID:   regs.long_event_id   = data[bgc_pkg::ID_W-1:0];
      bgc_pkg::REG_WINDOW_MS:       regs.window_ms       = data[bgc_pkg::WINDOW_W-1:0];
      default: ;
    endcase
  endfunction

  // apply the word, then look for a double press or an expired window
  function automatic bit classify(input bgc_pkg::item_t w, output gesture_word_t g);
    logic                          pressed;
    logic [bgc_pkg::TIME_IN_W-1:0] held;
    int unsigned                   long_limit;
    g = '0;
    pressed = regs.active_high ? w.pin_level : ~w.pin_level;
    if (w.cmd == bgc_pkg::CMD_PIN) begin
      if (!window_open && pressed) begin
        window_open = 1'b1;
        press_ms    = w.time_ms;
      end else if (window_open && !pressed) begin
        release_ms = w.time_ms;
        released   = 1'b1;
      end else if (window_open && pressed) begin
        second_press = 1'b1;
      end
    end
    if (!window_open) return 1'b0;
    if (!second_press && (w.time_ms - press_ms) < regs.window_ms) return 1'b0;

    held       = release_ms - press_ms;
    long_limit = (32'(regs.window_ms) * 3) / 4;
    if (second_press) g.code = bgc_pkg::GEST_DOUBLE;
    else if (!released) g.code = bgc_pkg::GEST_LONG;
    else if (held > long_limit) g.code = bgc_pkg::GEST_LONG;
    else g.code = bgc_pkg::GEST_SINGLE;

    if (g.code == bgc_pkg::GEST_DOUBLE) g.target = regs.double_event_id;
    else if (g.code == bgc_pkg::GEST_LONG) g.target = regs.long_event_id;
    else if (regs.local_mode) begin
      g.to_local = 1'b1;
      g.target   = bgc_pkg::ID_W'(regs.local_device_id);
    end else g.target = regs.single_event_id;
    close_window();
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      regs           = '0;
      regs.window_ms = bgc_pkg::WINDOW_RESET;
      close_window();
      gestures_due.delete();
    end else begin
      if (cfg_we) write_reg(cfg_index, cfg_data);
      if (item.valid && item.ready) begin
        word.cmd       = item.cmd;
        word.pin_level = item.pin_level;
        word.time_ms   = item.time_ms;
        if (classify(word, predicted)) gestures_due.push_back(predicted);
      end
      if (result.valid && result.ready) begin
        if (gestures_due.size() == 0) begin
          mismatches++;
          $display("%0t: result word expected none actual gesture %0d to_local %0d target %h",
                   $time, result.gesture, result.to_local, result.target_id);
        end else begin
          due = gestures_due.pop_front();
          if (result.gesture !== due.code) begin
            mismatches++;
            $display("%0t: gesture expected %0d actual %0d", $time, due.code, result.gesture);
          end
          if (result.to_local !== due.to_local) begin
            mismatches++;
            $display("%0t: to_local expected %0d actual %0d",
                     $time, due.to_local, result.to_local);
          end
          if (result.target_id !== due.target) begin
            mismatches++;
            $display("%0t: target_id expected %h actual %h",
                     $time, due.target, result.target_id);
          end
        end
      end
    end
    outstanding <= gestures_due.size();
    fail_count  <= mismatches;
  end

endmodule

// ===== dv/button_gesture_classifier_tb.sv =====
// testbench top: clock, reset, stimulus and verdict for the button gesture classifier
`timescale 1ns / 100ps

module button_gesture_classifier_tb;

  // index past the end of the register map, writes to it must be ignored
  localparam logic [bgc_pkg::CFG_INDEX_W-1:0] REG_SPARE = 3'd7;
  localparam int WORDS_PER_PHASE = 120;
  localparam int NUM_PHASES      = 6;
  // a result passes the input and result registers after its word, leave a little margin
  localparam int SETTLE_CYCLES   = 6;

  logic                            clk;
  logic                            rst;
  logic                            cfg_we;
  logic [bgc_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [bgc_pkg::CFG_DATA_W-1:0]  cfg_data;
  int                              fail_count;
  int                              outstanding;

  bgc_item_if   item_ch ();
  bgc_result_if result_ch ();

  // register values last written, used to shape gestures
  bgc_pkg::cfg_t                 cur_cfg;
  // running millisecond clock of the gesture generator
  logic [bgc_pkg::TIME_IN_W-1:0] clock_ms;
  int                            send_idle_pct = 8;
  int                            recv_idle_pct = 72;
  int                            words_sent = 0;

  button_gesture_classifier u_dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bgc_gesture_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .item        (item_ch),
    .result      (result_ch),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: stalls at random according to the current idle rate
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      result_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // hand one word over, with random idle cycles in front of it
  // returns at the edge where the word was taken, valid still high
  task automatic send_word(input logic c, input logic lvl,
                           input logic [bgc_pkg::TIME_IN_W-1:0] t);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.cmd       <= c;
    item_ch.pin_level <= lvl;
    item_ch.time_ms   <= t;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  // drop valid and wait until every predicted gesture has come out
  task automatic settle();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write the whole register map back to back, write enable held high throughout
  task automatic load_config(input bgc_pkg::cfg_t c, input bit poke_spare);
    cur_cfg = c;
    cfg_we    <= 1'b1;
    cfg_index <= bgc_pkg::REG_ACTIVE_HIGH;
    cfg_data  <= bgc_pkg::CFG_DATA_W'(c.active_high);
    @(posedge clk);
    cfg_index <= bgc_pkg::REG_LOCAL_MODE;
    cfg_data  <= bgc_pkg::CFG_DATA_W'(c.local_mode);
    @(posedge clk);
    cfg_index <= bgc_pkg::REG_LOCAL_DEVICE_ID;
    cfg_data  <= bgc_pkg::CFG_DATA_W'(c.local_device_id);
    @(posedge clk);
    cfg_index <= bgc_pkg::REG_SINGLE_EVENT_ID;
    cfg_data  <= c.single_event_id;
    @(posedge clk);
    cfg_index <= bgc_pkg::REG_DOUBLE_EVENT_ID;
    cfg_data  <= c.double_event_id;
    @(posedge clk);
    cfg_index <= bgc_pkg::REG_LONG_EVENT_ID;
    cfg_data  <= c.long_event_id;
    @(posedge clk);
    cfg_index <= bgc_pkg::REG_WINDOW_MS;
    cfg_data  <= bgc_pkg::CFG_DATA_W'(c.window_ms);
    @(posedge clk);
    if (poke_spare) begin
      cfg_index <= REG_SPARE;
      cfg_data  <= '1;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // one well-formed press with random timing, aimed at the threshold corners
  task automatic play_gesture();
    int unsigned                   win;
    int unsigned                   long_limit;
    int unsigned                   held;
    logic [bgc_pkg::TIME_IN_W-1:0] t0;
    logic                          down;
    bit                            doubled;
    win        = cur_cfg.window_ms;
    long_limit = (win * 3) / 4;
    down       = cur_cfg.active_high;
    t0         = clock_ms;
    doubled    = 1'b0;
    send_word(bgc_pkg::CMD_PIN, down, t0);
    // tick somewhere inside the window, must not close it
    if ($urandom_range(0, 3) == 0)
      send_word(bgc_pkg::CMD_TICK, 1'($urandom_range(0, 1)), t0 + $urandom_range(0, win - 1));
    case ($urandom_range(0, 4))
      0: begin
        // release one below, on or one above the long-press limit
        held = (long_limit == 0) ? $urandom_range(0, 1) : long_limit - 1 + $urandom_range(0, 2);
        send_word(bgc_pkg::CMD_PIN, ~down, t0 + held);
      end
      1: begin
        // random hold, sometimes a bounce so that the later release counts
        send_word(bgc_pkg::CMD_PIN, ~down, t0 + $urandom_range(0, win - 1));
        if ($urandom_range(0, 1))
          send_word(bgc_pkg::CMD_PIN, ~down, t0 + $urandom_range(0, win - 1));
      end
      2: ;  // held through the window: long press
      3: begin
        // second press closes the window at once
        if ($urandom_range(0, 1))
          send_word(bgc_pkg::CMD_PIN, ~down, t0 + $urandom_range(0, win - 1));
        send_word(bgc_pkg::CMD_PIN, down, t0 + $urandom_range(0, win - 1));
        doubled = 1'b1;
      end
      default: begin
        // release at the press time itself
        send_word(bgc_pkg::CMD_PIN, ~down, t0);
        if ($urandom_range(0, 2) == 0)
          send_word(bgc_pkg::CMD_PIN, ~down, t0 + $urandom_range(0, win - 1));
      end
    endcase
    if (!doubled) begin
      // one millisecond short of the window: nothing yet
      if ($urandom_range(0, 2) == 0)
        send_word(bgc_pkg::CMD_TICK, 1'($urandom_range(0, 1)), t0 + win - 1);
      // the closing word is mostly a tick, sometimes a late release
      if ($urandom_range(0, 3) == 0)
        send_word(bgc_pkg::CMD_PIN, ~down, t0 + win + $urandom_range(0, 3));
      else
        send_word(bgc_pkg::CMD_TICK, 1'($urandom_range(0, 1)), t0 + win + $urandom_range(0, 2));
    end
    clock_ms = t0 + win + $urandom_range(1, 4 * win);
  endtask

  // stray word: any command and level, time either anywhere or near the running clock
  task automatic noise_word();
    logic [bgc_pkg::TIME_IN_W-1:0] t;
    t = $urandom_range(0, 1) ? $urandom() : clock_ms + $urandom_range(0, cur_cfg.window_ms);
    send_word(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), t);
  endtask

  initial begin
    bgc_pkg::cfg_t c;
    int            stop_at;
    rst               <= 1'b1;
    item_ch.valid     <= 1'b0;
    item_ch.cmd       <= bgc_pkg::CMD_PIN;
    item_ch.pin_level <= 1'b0;
    item_ch.time_ms   <= '0;
    cfg_we            <= 1'b0;
    cfg_index         <= bgc_pkg::REG_ACTIVE_HIGH;
    cfg_data          <= '0;
    cur_cfg           = '0;
    cur_cfg.window_ms = bgc_pkg::WINDOW_RESET;
    clock_ms          = $urandom();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset registers: low level is pressed, 500 ms window, all ids zero
    send_word(bgc_pkg::CMD_PIN, 1'b0, 32'd1000);
    send_word(bgc_pkg::CMD_TICK, 1'b1, 32'd1500);
    settle();

    // directed corners with a 100 ms window, long-press limit of 75 ms
    c.active_high     = 1'b1;
    c.local_mode      = 1'b0;
    c.local_device_id = 16'hA5C3;
    c.single_event_id = 64'h1111_2222_3333_4444;
    c.double_event_id = 64'h5555_6666_7777_8888;
    c.long_event_id   = 64'h9999_AAAA_BBBB_CCCC;
    c.window_ms       = 16'd100;
    load_config(c, 1'b1);
    // tick and release with no window open are ignored
    send_word(bgc_pkg::CMD_TICK, 1'b0, 32'd2000);
    send_word(bgc_pkg::CMD_PIN, 1'b0, 32'd2005);
    // short click
    send_word(bgc_pkg::CMD_PIN, 1'b1, 32'd2010);
    send_word(bgc_pkg::CMD_PIN, 1'b0, 32'd2040);
    send_word(bgc_pkg::CMD_TICK, 1'b0, 32'd2110);
    // held exactly to the limit: still single
    send_word(bgc_pkg::CMD_PIN, 1'b1, 32'd2200);
    send_word(bgc_pkg::CMD_PIN, 1'b0, 32'd2275);
    send_word(bgc_pkg::CMD_TICK, 1'b0, 32'd2300);
    // one past the limit: long
    send_word(bgc_pkg::CMD_PIN, 1'b1, 32'd2400);
    send_word(bgc_pkg::CMD_PIN, 1'b0, 32'd2476);
    send_word(bgc_pkg::CMD_TICK, 1'b0, 32'd2500);
    // no release, window expires on the exact millisecond
    send_word(bgc_pkg::CMD_PIN, 1'b1, 32'd2600);
    send_word(bgc_pkg::CMD_TICK, 1'b1, 32'd2699);
    send_word(bgc_pkg::CMD_TICK, 1'b1, 32'd2700);
    // double press
    send_word(bgc_pkg::CMD_PIN, 1'b1, 32'd2800);
    send_word(bgc_pkg::CMD_PIN, 1'b1, 32'd2810);
    // zero-length release, then a later release that replaces it
    send_word(bgc_pkg::CMD_PIN, 1'b1, 32'd2900);
    send_word(bgc_pkg::CMD_PIN, 1'b0, 32'd2900);
    send_word(bgc_pkg::CMD_PIN, 1'b0, 32'd2950);
    send_word(bgc_pkg::CMD_TICK, 1'b0, 32'd3000);
    // timestamps wrapping through zero
    send_word(bgc_pkg::CMD_PIN, 1'b1, 32'hFFFF_FFFF);
    send_word(bgc_pkg::CMD_PIN, 1'b0, 32'h0000_0050);
    send_word(bgc_pkg::CMD_TICK, 1'b0, 32'h0000_0063);
    settle();

    // random phases: register extremes first, idle pattern changes every two phases
    for (int p = 0; p < NUM_PHASES; p++) begin
      c.active_high = p[0];
      c.local_mode  = (p == 2 || p == 3 || p == 5);
      if (p == 1) begin
        c.local_device_id = '1;
        c.single_event_id = '1;
        c.double_event_id = '1;
        c.long_event_id   = '1;
      end else if (p == 2) begin
        c.local_device_id = '0;
        c.single_event_id = '0;
        c.double_event_id = '0;
        c.long_event_id   = '0;
      end else begin
        c.local_device_id = 16'($urandom());
        c.single_event_id = {$urandom(), $urandom()};
        c.double_event_id = {$urandom(), $urandom()};
        c.long_event_id   = {$urandom(), $urandom()};
      end
      if (p == 0) c.window_ms = 16'd1;
      else if (p == 1) c.window_ms = 16'hFFFF;
      else if (p == 2) c.window_ms = 16'd4;
      else c.window_ms = 16'($urandom_range(1, 2000));
      send_idle_pct = (p < 2) ? 8 : (p < 4) ? 72 : 0;
      recv_idle_pct = (p < 2) ? 72 : (p < 4) ? 8 : 0;
      load_config(c, p == 3);
      stop_at = words_sent + WORDS_PER_PHASE;
      while (words_sent < stop_at) begin
        if ($urandom_range(0, 4) == 0) noise_word();
        else play_gesture();
      end
      settle();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS button_gesture_classifier");
    end else begin
      $display("FAIL button_gesture_classifier");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("FAIL button_gesture_classifier");
    $finish;
  end

endmodule
